>>> sv/pls_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pls_pkg
// Types and codes shared by the positional list store and its checker.
// ----------------------------------------------------------------------------
package pls_pkg;

    typedef enum logic [2:0] {
        OP_INS_FRONT = 3'd0,
        OP_INS_BACK  = 3'd1,
        OP_INS_POS   = 3'd2,
        OP_EXT_FRONT = 3'd3,
        OP_EXT_BACK  = 3'd4,
        OP_EXT_POS   = 3'd5
    } op_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_EMPTY  = 2'd1,
        ST_FULL   = 2'd2,
        ST_BADPOS = 2'd3
    } status_t;

    localparam logic signed [31:0] ERR_VALUE = -32'sd1;

    typedef struct packed {
        op_t                op;
        logic signed [31:0] data_value;
        logic [4:0]         position;
    } req_t;

    typedef struct packed {
        logic signed [31:0] out_value;
        status_t            status;
        logic [4:0]         entry_count;
    } rsp_t;

endpackage

>>> sv/pls_list_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pls_list_core
// Register list with entry count; shifts entries from a position on by one.
// ----------------------------------------------------------------------------
module pls_list_core #(
    parameter int LIST_DEPTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        en,
    input  pls_pkg::req_t req,
    output pls_pkg::rsp_t rsp
);
    import pls_pkg::*;

    localparam int CW    = $clog2(LIST_DEPTH + 1);
    localparam int IDXW  = $clog2(LIST_DEPTH);
    localparam int CMP_W = (CW > 5) ? CW : 5;

    logic signed [31:0] entries_reg [LIST_DEPTH];
    logic signed [31:0] entries_next [LIST_DEPTH];
    logic [CW-1:0]      count_reg;
    logic [CW-1:0]      count_next;

    logic [CMP_W-1:0]   cnt_x;
    logic [CMP_W-1:0]   pos_x;
    logic [CMP_W-1:0]   idx_x;
    logic [CMP_W-1:0]   cnt_new_x;
    logic               do_ins;
    logic               do_ext;
    logic               full;

    always_comb
    begin
        cnt_x  = CMP_W'(count_reg);
        pos_x  = CMP_W'(req.position);
        full   = (count_reg == CW'(LIST_DEPTH));
        idx_x  = '0;
        do_ins = 1'b0;
        do_ext = 1'b0;
        rsp.out_value = '0;
        rsp.status    = ST_OK;
        case (req.op)
            OP_INS_FRONT, OP_INS_BACK, OP_INS_POS:
            begin
                if (req.op == OP_INS_BACK)
                    idx_x = cnt_x;
                else if (req.op == OP_INS_POS)
                    idx_x = pos_x;
                if (full)
                begin
                    rsp.status    = ST_FULL;
                    rsp.out_value = ERR_VALUE;
                end
                else if (idx_x > cnt_x)
                begin
                    rsp.status    = ST_BADPOS;
                    rsp.out_value = ERR_VALUE;
                end
                else
                    do_ins = 1'b1;
            end
            OP_EXT_FRONT, OP_EXT_BACK, OP_EXT_POS:
            begin
                if (req.op == OP_EXT_BACK)
                    idx_x = cnt_x - CMP_W'(1);
                else if (req.op == OP_EXT_POS)
                    idx_x = pos_x;
                if (count_reg == '0)
                begin
                    rsp.status    = ST_EMPTY;
                    rsp.out_value = ERR_VALUE;
                end
                else if (idx_x >= cnt_x)
                begin
                    rsp.status    = ST_BADPOS;
                    rsp.out_value = ERR_VALUE;
                end
                else
                begin
                    do_ext        = 1'b1;
                    rsp.out_value = entries_reg[idx_x[IDXW-1:0]];
                end
            end
            default:
            begin
                idx_x = '0;
            end
        endcase

        if (do_ins)
            count_next = count_reg + CW'(1);
        else if (do_ext)
            count_next = count_reg - CW'(1);
        else
            count_next = count_reg;
        cnt_new_x       = CMP_W'(count_next);
        rsp.entry_count = cnt_new_x[4:0];
    end

    always_comb
    begin
        for (int i = 0; i < LIST_DEPTH; i++)
        begin
            entries_next[i] = entries_reg[i];
            if (do_ins && CMP_W'(i) >= idx_x)
            begin
                if (CMP_W'(i) == idx_x)
                    entries_next[i] = req.data_value;
                else if (i > 0)
                    entries_next[i] = entries_reg[i-1];
            end
            else if (do_ext && CMP_W'(i) >= idx_x && i < LIST_DEPTH - 1)
                entries_next[i] = entries_reg[i+1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
            entries_reg <= entries_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else if (en)
            count_reg <= count_next;
    end

endmodule

>>> sv/positional_list_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// positional_list_store
// Bounded ordered list of signed 32-bit values with front, back and
// positional insert and extract.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on req / req_valid / req_ready, one operation each.
//   Every request gives exactly one response on rsp / rsp_valid / rsp_ready
//   with the extracted value, a status and the entry count afterwards.
//   A request lands in an input register, is worked out combinationally by
//   the list core, and its response is held in an output register; rsp_valid
//   rises once the request moves on from the input register into the output
//   register. Throughput is one request per cycle while rsp_ready stays
//   high; the entries from the request's position onward move by one place
//   as the request advances, so the count seen by the next request is
//   always current.
//   While the receiver stalls, the response holds and one more request may
//   wait in the input register; req_ready then drops until rsp_ready.
//   Reset empties the list and drops any request or response in flight;
//   entry contents are not cleared and are never read before written.
// ----------------------------------------------------------------------------
module positional_list_store #(
    parameter int LIST_DEPTH = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  pls_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output pls_pkg::rsp_t rsp
);
    import pls_pkg::*;

    logic  in_valid_reg;
    req_t  in_req_reg;
    logic  out_valid_reg;
    rsp_t  out_rsp_reg;
    rsp_t  core_rsp;
    logic  advance;

    assign advance   = in_valid_reg && (!out_valid_reg || rsp_ready);
    assign req_ready = !in_valid_reg || advance;
    assign rsp_valid = out_valid_reg;
    assign rsp       = out_rsp_reg;

    pls_list_core #(
        .LIST_DEPTH(LIST_DEPTH)
    ) u_core (
        .clk  (clk),
        .rst_n(rst_n),
        .en   (advance),
        .req  (in_req_reg),
        .rsp  (core_rsp)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (req_ready)
                in_valid_reg <= req_valid;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (rsp_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_ready && req_valid)
            in_req_reg <= req;
        if (advance)
            out_rsp_reg <= core_rsp;
    end

endmodule

>>> sv/pls_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pls_checker
// Port-level checks for the positional list store, bound to the top level.
// ----------------------------------------------------------------------------
module pls_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          req_ready,
    input logic          rsp_valid,
    input logic          rsp_ready,
    input pls_pkg::rsp_t rsp
);
    import pls_pkg::*;

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("response changed while stalled");

    a_err_value: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status != ST_OK |-> rsp.out_value == ERR_VALUE)
        else $error("error response without error value");

    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status == ST_EMPTY |-> rsp.entry_count == 5'd0)
        else $error("empty status with non-zero count");

    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !rsp_valid |-> req_ready)
        else $error("request refused with no response pending");

endmodule

bind positional_list_store pls_checker u_pls_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .req_ready(req_ready),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp      (rsp)
);
